// File: hdl/nbdba_pkg.sv
// ----------------------------------------------------------------------------
// nbdba_pkg
// Shared types, codes and field positions for the named block directory.
// ----------------------------------------------------------------------------
`default_nettype none

package nbdba_pkg;

  // default sizes
  localparam int ENTRIES_DEF    = 64;
  localparam int NAME_BYTES_DEF = 16;

  // field widths
  localparam int CMD_W     = 2;
  localparam int NAME_HI_W = 56;
  localparam int NAME_LO_W = 64;
  localparam int SIZE_W    = 23;
  localparam int OFF_W     = 22;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 6;
  localparam int CAP_W     = 23;

  // input transaction packing
  localparam int IN_NHI_LSB  = 0;
  localparam int IN_NLO_LSB  = IN_NHI_LSB + NAME_HI_W;
  localparam int IN_SIZE_LSB = IN_NLO_LSB + NAME_LO_W;
  localparam int IN_DATA_W   = ((IN_SIZE_LSB + SIZE_W + 7) / 8) * 8;

  // output transaction packing
  localparam int OUT_ST_LSB   = 0;
  localparam int OUT_OFF_LSB  = OUT_ST_LSB + STATUS_W;
  localparam int OUT_SIZE_LSB = OUT_OFF_LSB + OFF_W;
  localparam int OUT_SLOT_LSB = OUT_SIZE_LSB + SIZE_W;
  localparam int OUT_USED_W   = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_CAPACITY = '0;

  // allocator constants
  localparam logic [SIZE_W-1:0] DATA_START = SIZE_W'(16 * 1024);
  localparam logic [CAP_W-1:0]  CAP_MAX    = CAP_W'(4194304);

  // commands
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_RAM    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ODD_SIZE  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_BUF_SMALL = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/nbdba_cfg.sv
// ----------------------------------------------------------------------------
// nbdba_cfg
// Register port holding the detected RAM capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module nbdba_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [nbdba_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [nbdba_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [nbdba_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                   cfg_pready,
  output logic      [nbdba_pkg::CAP_W-1:0]       capacity
);

  logic [nbdba_pkg::CAP_W-1:0] cap_r;
  logic [nbdba_pkg::CAP_W-1:0] cap_nxt;
  logic                        hit;
  logic                        wr_en;

  assign cfg_pready = 1'b1;
  assign hit        = (cfg_paddr[nbdba_pkg::CFG_ADDR_W-1:2] == nbdba_pkg::REG_CAPACITY);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && hit;
  assign cap_nxt    = wr_en ? cfg_pwdata[nbdba_pkg::CAP_W-1:0] : cap_r;
  assign capacity   = cap_r;

  always_comb begin
    cfg_prdata = '0;
    if (hit) begin
      cfg_prdata = nbdba_pkg::CFG_DATA_W'(cap_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else begin
      cap_r <= cap_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/nbdba_ctrl.sv
// ----------------------------------------------------------------------------
// nbdba_ctrl
// Command sequencer: accept, directory scan, commit of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module nbdba_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire nbdba_pkg::sts_t sts,
  output nbdba_pkg::ctl_t      ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign ctl.load   = in_tvalid && in_tready;
  assign ctl.scan   = (state_r == S_SCAN);
  assign ctl.commit = (state_r == S_COMMIT) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.load) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = sts.need_scan ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/nbdba_dp.sv
// ----------------------------------------------------------------------------
// nbdba_dp
// Directory datapath: key forming, directory RAMs, scan compare, allocator
// and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nbdba_dp #(
  parameter int ENTRIES    = nbdba_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = nbdba_pkg::NAME_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [nbdba_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic [nbdba_pkg::CMD_W-1:0]       in_tuser,
  input  wire nbdba_pkg::ctl_t                   ctl,
  output nbdba_pkg::sts_t                        sts,
  input  wire logic [nbdba_pkg::CAP_W-1:0]       capacity,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [nbdba_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int NB     = NAME_BYTES - 1;
  localparam int NAME_W = NB * 8;
  localparam int RAW_W  = nbdba_pkg::NAME_HI_W + nbdba_pkg::NAME_LO_W + 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam int SW = nbdba_pkg::SIZE_W;
  localparam int OW = nbdba_pkg::OFF_W;
  localparam int TW = nbdba_pkg::STATUS_W;

  // input fields
  logic [nbdba_pkg::NAME_HI_W-1:0] in_name_high;
  logic [nbdba_pkg::NAME_LO_W-1:0] in_name_low;
  logic [SW-1:0]                   in_size;
  logic [RAW_W-1:0]                raw;

  assign in_name_high = in_tdata[nbdba_pkg::IN_NHI_LSB +: nbdba_pkg::NAME_HI_W];
  assign in_name_low  = in_tdata[nbdba_pkg::IN_NLO_LSB +: nbdba_pkg::NAME_LO_W];
  assign in_size      = in_tdata[nbdba_pkg::IN_SIZE_LSB +: SW];
  assign raw          = {in_name_high, in_name_low, 8'd0};

  // key forming: stop at the first zero byte
  logic [NAME_W-1:0] key_nxt;
  logic              tail_nz_nxt;
  logic              alive;

  always_comb begin
    alive   = 1'b1;
    key_nxt = '0;
    for (int i = 0; i < NB; i++) begin
      if (raw[RAW_W-1-8*i -: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        key_nxt[NAME_W-1-8*i -: 8] = raw[RAW_W-1-8*i -: 8];
      end
    end
    tail_nz_nxt = alive && (raw[RAW_W-1-8*NB -: 8] != 8'd0);
  end

  // early checks at accept
  logic [SW-1:0]  next_free_r;
  logic [SW-1:0]  next_free_nxt;
  logic [nbdba_pkg::CAP_W-1:0] cap_eff;
  logic [SW:0]    need_sum;
  logic           early_nxt;
  logic [TW-1:0]  early_st_nxt;

  assign cap_eff  = (capacity > nbdba_pkg::CAP_MAX) ? nbdba_pkg::CAP_MAX : capacity;
  assign need_sum = {1'b0, in_size} + {1'b0, next_free_r};

  always_comb begin
    early_nxt    = 1'b0;
    early_st_nxt = nbdba_pkg::ST_OK;
    if (in_tuser == nbdba_pkg::CMD_CLEAR) begin
      early_nxt = 1'b1;
    end else if (in_tuser != nbdba_pkg::CMD_DELETE) begin
      if (in_size == '0) begin
        early_nxt    = 1'b1;
        early_st_nxt = nbdba_pkg::ST_ZERO_SIZE;
      end else if (cap_eff == '0) begin
        early_nxt    = 1'b1;
        early_st_nxt = nbdba_pkg::ST_NO_RAM;
      end else if ((in_tuser == nbdba_pkg::CMD_STORE) && (need_sum > {1'b0, cap_eff})) begin
        early_nxt    = 1'b1;
        early_st_nxt = nbdba_pkg::ST_NO_SPACE;
      end
    end
  end

  // command registers
  logic [nbdba_pkg::CMD_W-1:0] cmd_r;
  logic [SW-1:0]               size_r;
  logic [NAME_W-1:0]           key_r;
  logic                        tail_nz_r;
  logic                        early_r;
  logic [TW-1:0]               early_st_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r      <= in_tuser;
      size_r     <= in_size;
      key_r      <= key_nxt;
      tail_nz_r  <= tail_nz_nxt;
      early_r    <= early_nxt;
      early_st_r <= early_st_nxt;
    end
  end

  // directory rams
  logic [NAME_W-1:0] name_mem [ENTRIES];
  logic [OW-1:0]     off_mem  [ENTRIES];
  logic [SW-1:0]     size_mem [ENTRIES];

  logic [IDX_W-1:0]   scan_cnt_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [NAME_W-1:0]  rd_name_r;
  logic [OW-1:0]      rd_off_r;
  logic [SW-1:0]      rd_size_r;
  logic               rd_vld_r;
  logic               rd_live_r;
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;

  logic               name_we;
  logic               size_we;
  logic [IDX_W-1:0]   wr_idx;

  always_ff @(posedge clk) begin
    if (name_we) begin
      name_mem[wr_idx] <= key_r;
      off_mem[wr_idx]  <= next_free_r[OW-1:0];
    end
    if (size_we) begin
      size_mem[wr_idx] <= size_r;
    end
    rd_name_r <= name_mem[scan_cnt_r];
    rd_off_r  <= off_mem[scan_cnt_r];
    rd_size_r <= size_mem[scan_cnt_r];
    rd_idx_r  <= scan_cnt_r;
    rd_vld_r  <= valid_r[scan_cnt_r];
  end

  // scan compare
  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic [OW-1:0]    found_off_r;
  logic [SW-1:0]    found_size_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             hit;
  logic             hole;

  assign hit  = rd_live_r && rd_vld_r && !tail_nz_r && (rd_name_r == key_r) && !found_r;
  assign hole = rd_live_r && !rd_vld_r && !free_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r   <= '0;
      rd_live_r    <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      rd_live_r <= ctl.scan;
      if (ctl.load) begin
        scan_cnt_r   <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (ctl.scan) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        if (hit) begin
          found_r <= 1'b1;
        end
        if (hole) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      found_idx_r  <= rd_idx_r;
      found_off_r  <= rd_off_r;
      found_size_r <= rd_size_r;
    end
    if (hole) begin
      free_idx_r <= rd_idx_r;
    end
  end

  // result and state update
  logic [TW-1:0]    res_st;
  logic [OW-1:0]    res_off;
  logic [SW-1:0]    res_sz;
  logic [IDX_W-1:0] res_idx;
  logic [IDX_W-1:0] alloc_idx;
  logic             clr_all;
  logic             v_clr;
  logic             v_set;
  logic             do_name;
  logic             do_size;
  logic             nf_adv;

  assign alloc_idx = (free_found_r && (free_idx_r < found_idx_r)) ? free_idx_r : found_idx_r;

  always_comb begin
    res_st  = nbdba_pkg::ST_OK;
    res_off = '0;
    res_sz  = '0;
    res_idx = '0;
    clr_all = 1'b0;
    v_clr   = 1'b0;
    v_set   = 1'b0;
    do_name = 1'b0;
    do_size = 1'b0;
    nf_adv  = 1'b0;
    if (early_r) begin
      res_st  = early_st_r;
      clr_all = (cmd_r == nbdba_pkg::CMD_CLEAR);
    end else begin
      case (cmd_r)
        nbdba_pkg::CMD_DELETE: begin
          if (!found_r) begin
            res_st = nbdba_pkg::ST_NOT_FOUND;
          end else begin
            v_clr   = 1'b1;
            res_off = found_off_r;
            res_sz  = found_size_r;
            res_idx = found_idx_r;
          end
        end
        nbdba_pkg::CMD_LOOKUP: begin
          if (!found_r) begin
            res_st = nbdba_pkg::ST_NOT_FOUND;
          end else begin
            res_off = found_off_r;
            res_sz  = found_size_r;
            res_idx = found_idx_r;
            if (size_r < found_size_r) begin
              res_st = nbdba_pkg::ST_BUF_SMALL;
            end else if (found_size_r[0]) begin
              res_st = nbdba_pkg::ST_ODD_SIZE;
            end
          end
        end
        nbdba_pkg::CMD_STORE: begin
          if (found_r && (found_size_r >= size_r)) begin
            do_size = 1'b1;
            res_st  = size_r[0] ? nbdba_pkg::ST_ODD_SIZE : nbdba_pkg::ST_OK;
            res_off = found_off_r;
            res_sz  = size_r;
            res_idx = found_idx_r;
          end else begin
            v_clr = found_r;
            if (!found_r && !free_found_r) begin
              res_st = nbdba_pkg::ST_FULL;
            end else begin
              res_idx = found_r ? alloc_idx : free_idx_r;
              res_off = next_free_r[OW-1:0];
              res_sz  = size_r;
              if (size_r[0]) begin
                res_st = nbdba_pkg::ST_ODD_SIZE;
              end else begin
                v_set   = 1'b1;
                do_name = 1'b1;
                do_size = 1'b1;
                nf_adv  = 1'b1;
              end
            end
          end
        end
        default: begin
          res_st = nbdba_pkg::ST_OK;
        end
      endcase
    end
  end

  assign name_we = ctl.commit && do_name;
  assign size_we = ctl.commit && do_size;
  assign wr_idx  = res_idx;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.commit) begin
      if (clr_all) begin
        valid_nxt = '0;
      end
      if (v_clr) begin
        valid_nxt[found_idx_r] = 1'b0;
      end
      if (v_set) begin
        valid_nxt[res_idx] = 1'b1;
      end
    end
  end

  always_comb begin
    next_free_nxt = next_free_r;
    if (ctl.commit && clr_all) begin
      next_free_nxt = nbdba_pkg::DATA_START;
    end else if (ctl.commit && nf_adv) begin
      next_free_nxt = next_free_r + size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      next_free_r <= nbdba_pkg::DATA_START;
    end else begin
      valid_r     <= valid_nxt;
      next_free_r <= next_free_nxt;
    end
  end

  // result register
  logic                             out_tvalid_r;
  logic                             out_tvalid_nxt;
  logic [nbdba_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [IDX_W+5:0]                 slot_ext;

  assign slot_ext = {6'd0, res_idx};

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (ctl.commit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_tdata_r <= nbdba_pkg::OUT_DATA_W'({slot_ext[5:0], res_sz, res_off, res_st});
    end
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_tdata     = out_tdata_r;
  assign sts.need_scan = !early_r;
  assign sts.scan_last = (scan_cnt_r == LAST_IDX);
  assign sts.out_free  = !out_tvalid_r || out_tready;

endmodule

`default_nettype wire

// File: hdl/named_block_directory_bump_alloc_unit.sv
// ----------------------------------------------------------------------------
// named_block_directory_bump_alloc_unit
// Directory of named RAM blocks with a bump allocator.
// ----------------------------------------------------------------------------
// Each command (store, lookup, delete, clear) returns one result transaction.
// Store, lookup and delete walk every directory slot, one slot per cycle
// through the directory RAMs, before the result is committed; clear and
// commands rejected by the size or capacity checks skip the scan. A new
// command is taken once the previous one has been placed in the output
// register, even while that result still waits for the downstream side.
// Write the capacity register only while no command is in flight.
`default_nettype none

module named_block_directory_bump_alloc_unit #(
  parameter int ENTRIES    = nbdba_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = nbdba_pkg::NAME_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // name_high [55:0], name_low [119:56], size_bytes [142:120]
  input  wire logic [nbdba_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd [1:0]
  input  wire logic [nbdba_pkg::CMD_W-1:0]       in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // status [2:0], block_offset [24:3], block_size [47:25], slot [53:48]
  output logic      [nbdba_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [nbdba_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [nbdba_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [nbdba_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                   cfg_pready
);

  nbdba_pkg::ctl_t             ctl;
  nbdba_pkg::sts_t             sts;
  logic [nbdba_pkg::CAP_W-1:0] capacity;

  nbdba_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .capacity    (capacity)
  );

  nbdba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  nbdba_dp #(
    .ENTRIES    (ENTRIES),
    .NAME_BYTES (NAME_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ctl        (ctl),
    .sts        (sts),
    .capacity   (capacity),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: hdl/nbdba_checker.sv
// ----------------------------------------------------------------------------
// nbdba_checker
// Port-level checks for the named block directory, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nbdba_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [nbdba_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [nbdba_pkg::STATUS_W-1:0] st;
  logic                           no_slot;

  assign st      = out_tdata[nbdba_pkg::OUT_ST_LSB +: nbdba_pkg::STATUS_W];
  assign no_slot = st inside {nbdba_pkg::ST_ZERO_SIZE, nbdba_pkg::ST_NO_RAM,
                              nbdba_pkg::ST_NO_SPACE, nbdba_pkg::ST_NOT_FOUND,
                              nbdba_pkg::ST_FULL};

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while busy");

  // statuses without a slot carry zero fields
  a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && no_slot
    |-> out_tdata[nbdba_pkg::OUT_USED_W-1:nbdba_pkg::OUT_OFF_LSB] == '0)
    else $error("non-zero fields on a status without slot");

  // allocation only advances by even sizes
  a_even_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[nbdba_pkg::OUT_OFF_LSB])
    else $error("odd block offset");

endmodule

bind named_block_directory_bump_alloc_unit nbdba_checker u_nbdba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: bench/named_block_directory_bump_alloc_unit_tb.sv
// ----------------------------------------------------------------------------
// named_block_directory_bump_alloc_unit_tb
// Self-checking bench for the named block directory. Commands go in on the
// input stream; an in-bench directory with its own bump pointer predicts
// every result, and each result transaction is checked field by field.
// Directed cases come first, then a table fill, random phases at several
// capacities, a long downstream hold-off and a gap-free stretch.
// ----------------------------------------------------------------------------
module named_block_directory_bump_alloc_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_SLOTS = nbdba_pkg::ENTRIES_DEF;
  localparam int NAME_W = nbdba_pkg::NAME_HI_W + nbdba_pkg::NAME_LO_W;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [nbdba_pkg::CFG_ADDR_W-1:0] CAP_ADDR =
    nbdba_pkg::CFG_ADDR_W'({nbdba_pkg::REG_CAPACITY, 2'b00});

  localparam logic [NAME_W-1:0] NAME_ALPHA = {"alpha", 80'd0};
  localparam logic [NAME_W-1:0] NAME_ALPHA_TAIL = {"alpha", 8'h00, 72'h0123456789abcdef55};
  localparam logic [NAME_W-1:0] NAME_GAMMA = {"gamma", 80'd0};
  localparam logic [NAME_W-1:0] NAME_ONES = {NAME_W{1'b1}};
  localparam logic [NAME_W-1:0] NAME_EMPTY = '0;

  typedef struct packed {
    logic [nbdba_pkg::SLOT_W-1:0]   slot;
    logic [nbdba_pkg::SIZE_W-1:0]   size;
    logic [nbdba_pkg::OFF_W-1:0]    offset;
    logic [nbdba_pkg::STATUS_W-1:0] status;
  } dir_result_t;

  logic                             clk;
  logic                             rst_n;
  // name_high, name_low, size_bytes (from bit 0 up)
  logic [nbdba_pkg::IN_DATA_W-1:0]  in_tdata;
  // cmd
  logic [nbdba_pkg::CMD_W-1:0]      in_tuser;
  logic                             in_tvalid;
  logic                             in_tready;
  // status, block_offset, block_size, slot (from bit 0 up)
  logic [nbdba_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic                             cfg_psel;
  logic                             cfg_penable;
  logic                             cfg_pwrite;
  logic [nbdba_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [nbdba_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [nbdba_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                             cfg_pready;

  named_block_directory_bump_alloc_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // in-bench copy of the directory
  logic                         dir_valid [DIR_SLOTS];
  logic [NAME_W-1:0]            dir_key   [DIR_SLOTS];
  logic [nbdba_pkg::OFF_W-1:0]  dir_off   [DIR_SLOTS];
  logic [nbdba_pkg::SIZE_W-1:0] dir_size  [DIR_SLOTS];
  logic [nbdba_pkg::SIZE_W-1:0] alloc_ptr;
  logic [nbdba_pkg::CAP_W-1:0]  capacity_reg;

  dir_result_t       pending_results [$];
  logic [NAME_W-1:0] name_pool [$];
  dir_result_t       exp_r;
  dir_result_t       act_r;
  int                mismatches;
  int                holds_requested;
  bit                valid_gaps;
  bit                ready_gaps;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // name ends at its first zero byte
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] k;
    bit ended;
    k = n;
    ended = 1'b0;
    for (int i = 0; i < NAME_W / 8; i++) begin
      if (k[NAME_W-1-8*i -: 8] == 8'h00) ended = 1'b1;
      if (ended) k[NAME_W-1-8*i -: 8] = 8'h00;
    end
    return k;
  endfunction

  function automatic int find_entry(input logic [NAME_W-1:0] key);
    for (int i = 0; i < DIR_SLOTS; i++)
      if (dir_valid[i] && dir_key[i] == key) return i;
    return -1;
  endfunction

  function automatic dir_result_t slot_result(input logic [nbdba_pkg::STATUS_W-1:0] st,
                                              input int s);
    dir_result_t r;
    r.status = st;
    r.offset = dir_off[s];
    r.size   = dir_size[s];
    r.slot   = nbdba_pkg::SLOT_W'(s);
    return r;
  endfunction

  function automatic dir_result_t predict_directory(input logic [nbdba_pkg::CMD_W-1:0] cmd,
                                                    input logic [NAME_W-1:0] name,
                                                    input logic [nbdba_pkg::SIZE_W-1:0] size);
    dir_result_t r;
    logic [NAME_W-1:0] key;
    logic [nbdba_pkg::CAP_W-1:0] cap;
    int s;
    r = '0;
    key = canon_name(name);
    cap = (capacity_reg > nbdba_pkg::CAP_MAX) ? nbdba_pkg::CAP_MAX : capacity_reg;
    s = find_entry(key);
    if (cmd == nbdba_pkg::CMD_CLEAR) begin
      foreach (dir_valid[i]) dir_valid[i] = 1'b0;
      alloc_ptr = nbdba_pkg::DATA_START;
      r.status = nbdba_pkg::ST_OK;
    end else if (cmd == nbdba_pkg::CMD_DELETE) begin
      if (s < 0) begin
        r.status = nbdba_pkg::ST_NOT_FOUND;
      end else begin
        dir_valid[s] = 1'b0;
        r = slot_result(nbdba_pkg::ST_OK, s);
      end
    end else if (size == '0) begin
      r.status = nbdba_pkg::ST_ZERO_SIZE;
    end else if (cap == '0) begin
      r.status = nbdba_pkg::ST_NO_RAM;
    end else if (cmd == nbdba_pkg::CMD_LOOKUP) begin
      if (s < 0) r.status = nbdba_pkg::ST_NOT_FOUND;
      else if (size < dir_size[s]) r = slot_result(nbdba_pkg::ST_BUF_SMALL, s);
      else if (dir_size[s][0]) r = slot_result(nbdba_pkg::ST_ODD_SIZE, s);
      else r = slot_result(nbdba_pkg::ST_OK, s);
    end else if ({1'b0, size} + {1'b0, alloc_ptr} > {1'b0, cap}) begin
      r.status = nbdba_pkg::ST_NO_SPACE;
    end else if (s >= 0 && dir_size[s] >= size) begin
      // reuse in place, odd sizes still resize
      dir_size[s] = size;
      r = slot_result(size[0] ? nbdba_pkg::ST_ODD_SIZE : nbdba_pkg::ST_OK, s);
    end else begin
      if (s >= 0) dir_valid[s] = 1'b0;
      s = -1;
      for (int i = DIR_SLOTS - 1; i >= 0; i--)
        if (!dir_valid[i]) s = i;
      if (s < 0) begin
        r.status = nbdba_pkg::ST_FULL;
      end else begin
        r.status = size[0] ? nbdba_pkg::ST_ODD_SIZE : nbdba_pkg::ST_OK;
        r.offset = alloc_ptr[nbdba_pkg::OFF_W-1:0];
        r.size   = size;
        r.slot   = nbdba_pkg::SLOT_W'(s);
        if (!size[0]) begin
          dir_valid[s] = 1'b1;
          dir_key[s]   = key;
          dir_off[s]   = alloc_ptr[nbdba_pkg::OFF_W-1:0];
          dir_size[s]  = size;
          alloc_ptr    = alloc_ptr + size;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [NAME_W-1:0] fresh_name(input int unsigned len);
    logic [NAME_W-1:0] n;
    n = '0;
    for (int i = 0; i < NAME_W / 8; i++)
      if (i < len) n[NAME_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
    return n;
  endfunction

  // random bytes after the terminator, half of the time
  function automatic logic [NAME_W-1:0] dress_name(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] d;
    bit ended;
    d = n;
    ended = 1'b0;
    if ($urandom_range(0, 1) == 0) return d;
    for (int i = 0; i < NAME_W / 8; i++) begin
      if (ended) d[NAME_W-1-8*i -: 8] = 8'($urandom);
      if (n[NAME_W-1-8*i -: 8] == 8'h00) ended = 1'b1;
    end
    return d;
  endfunction

  function automatic logic [NAME_W-1:0] pick_name();
    if ($urandom_range(0, 99) < 85)
      return dress_name(name_pool[$urandom_range(0, name_pool.size() - 1)]);
    return dress_name(fresh_name($urandom_range(0, 15)));
  endfunction

  task automatic fill_pool(input int unsigned count);
    name_pool.delete();
    repeat (count) name_pool.push_back(fresh_name($urandom_range(0, 15)));
  endtask

  task automatic send_command(input logic [nbdba_pkg::CMD_W-1:0] cmd,
                              input logic [NAME_W-1:0] name,
                              input logic [nbdba_pkg::SIZE_W-1:0] size);
    if (valid_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tdata  <= nbdba_pkg::IN_DATA_W'({size, name[nbdba_pkg::NAME_LO_W-1:0],
                                        name[NAME_W-1:nbdba_pkg::NAME_LO_W]});
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_directory(cmd, name, size));
  endtask

  task automatic random_command(input int unsigned clear_pct);
    int unsigned roll;
    logic [nbdba_pkg::CMD_W-1:0] cmd;
    logic [nbdba_pkg::SIZE_W-1:0] size;
    roll = $urandom_range(0, 99);
    if (roll < clear_pct) cmd = nbdba_pkg::CMD_CLEAR;
    else if (roll < clear_pct + 12) cmd = nbdba_pkg::CMD_DELETE;
    else if (roll < clear_pct + 42) cmd = nbdba_pkg::CMD_LOOKUP;
    else cmd = nbdba_pkg::CMD_STORE;
    roll = $urandom_range(0, 99);
    if (roll < 5) size = '0;
    else if (roll < 12) size = nbdba_pkg::SIZE_W'($urandom);
    else if (roll < 22)
      size = nbdba_pkg::SIZE_W'($urandom_range(0, 2047)) | nbdba_pkg::SIZE_W'(1);
    else if (roll < 32) size = nbdba_pkg::SIZE_W'(2 * $urandom_range(1, 65536));
    else size = nbdba_pkg::SIZE_W'(2 * $urandom_range(1, 1024));
    send_command(cmd, pick_name(), size);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write, then read back
  task automatic set_capacity(input logic [nbdba_pkg::CFG_DATA_W-1:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CAP_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    capacity_reg = wdata[nbdba_pkg::CAP_W-1:0];
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== nbdba_pkg::CFG_DATA_W'(capacity_reg)) begin
      $display("%0t: capacity read-back mismatch: expected %0h, actual %0h",
               $time, capacity_reg, cfg_prdata);
      mismatches++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_directed();
    // no ram present after reset
    send_command(nbdba_pkg::CMD_STORE, NAME_ALPHA, nbdba_pkg::SIZE_W'(4096));
    send_command(nbdba_pkg::CMD_LOOKUP, NAME_ALPHA, nbdba_pkg::SIZE_W'(4096));
    send_command(nbdba_pkg::CMD_STORE, NAME_ALPHA, '0);
    send_command(nbdba_pkg::CMD_DELETE, NAME_ALPHA, '0);
    send_command(nbdba_pkg::CMD_CLEAR, NAME_EMPTY, '0);
    drain_results();
    set_capacity(nbdba_pkg::CFG_DATA_W'(nbdba_pkg::CAP_MAX));
    send_command(nbdba_pkg::CMD_STORE, NAME_ALPHA, nbdba_pkg::SIZE_W'(4096));
    send_command(nbdba_pkg::CMD_STORE, NAME_ONES, nbdba_pkg::SIZE_W'(2));
    send_command(nbdba_pkg::CMD_LOOKUP, NAME_ONES, {nbdba_pkg::SIZE_W{1'b1}});
    send_command(nbdba_pkg::CMD_LOOKUP, NAME_ALPHA_TAIL, nbdba_pkg::SIZE_W'(4096));
    send_command(nbdba_pkg::CMD_LOOKUP, NAME_ALPHA, nbdba_pkg::SIZE_W'(100));
    send_command(nbdba_pkg::CMD_STORE, NAME_ALPHA, nbdba_pkg::SIZE_W'(1000));
    send_command(nbdba_pkg::CMD_STORE, NAME_ALPHA, nbdba_pkg::SIZE_W'(999));
    send_command(nbdba_pkg::CMD_LOOKUP, NAME_ALPHA, nbdba_pkg::SIZE_W'(999));
    send_command(nbdba_pkg::CMD_LOOKUP, NAME_ALPHA, nbdba_pkg::SIZE_W'(998));
    send_command(nbdba_pkg::CMD_STORE, NAME_ALPHA_TAIL, nbdba_pkg::SIZE_W'(5000));
    send_command(nbdba_pkg::CMD_STORE, NAME_GAMMA, nbdba_pkg::SIZE_W'(7));
    send_command(nbdba_pkg::CMD_LOOKUP, NAME_GAMMA, nbdba_pkg::SIZE_W'(8));
    send_command(nbdba_pkg::CMD_DELETE, NAME_ONES, '0);
    send_command(nbdba_pkg::CMD_DELETE, NAME_ONES, '0);
    send_command(nbdba_pkg::CMD_STORE, NAME_EMPTY, nbdba_pkg::SIZE_W'(nbdba_pkg::CAP_MAX));
    send_command(nbdba_pkg::CMD_STORE, NAME_GAMMA, {nbdba_pkg::SIZE_W{1'b1}});
    send_command(nbdba_pkg::CMD_LOOKUP, NAME_ALPHA, '0);
    send_command(nbdba_pkg::CMD_CLEAR, NAME_ONES, {nbdba_pkg::SIZE_W{1'b1}});
    send_command(nbdba_pkg::CMD_LOOKUP, NAME_ALPHA, nbdba_pkg::SIZE_W'(4096));
  endtask

  task automatic test_table_full();
    drain_results();
    set_capacity({9'h1ff, {nbdba_pkg::CAP_W{1'b1}}});
    send_command(nbdba_pkg::CMD_CLEAR, NAME_EMPTY, '0);
    repeat (DIR_SLOTS + 6)
      send_command(nbdba_pkg::CMD_STORE, fresh_name(15),
                   nbdba_pkg::SIZE_W'(2 * $urandom_range(1, 32)));
    fill_pool(DIR_SLOTS + 8);
    repeat (10) random_command(0);
  endtask

  task automatic test_random_phases();
    logic [nbdba_pkg::CAP_W-1:0] caps [6];
    int unsigned pool_sizes [6];
    caps[0] = nbdba_pkg::CAP_MAX;
    caps[1] = {nbdba_pkg::CAP_W{1'b1}};
    caps[2] = nbdba_pkg::DATA_START + nbdba_pkg::CAP_W'(12000);
    caps[3] = nbdba_pkg::CAP_W'($urandom_range(0, nbdba_pkg::CAP_MAX));
    caps[4] = '0;
    caps[5] = nbdba_pkg::DATA_START + nbdba_pkg::CAP_W'(2);
    pool_sizes[0] = 10;
    pool_sizes[1] = 40;
    pool_sizes[2] = 8;
    pool_sizes[3] = 16;
    pool_sizes[4] = 10;
    pool_sizes[5] = 6;
    for (int p = 0; p < 6; p++) begin
      drain_results();
      set_capacity({9'($urandom), caps[p]});
      fill_pool(pool_sizes[p]);
      if (p % 2 == 0)
        send_command(nbdba_pkg::CMD_CLEAR, pick_name(), nbdba_pkg::SIZE_W'($urandom));
      repeat (110) random_command(2);
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    set_capacity(nbdba_pkg::CFG_DATA_W'(nbdba_pkg::CAP_MAX));
    fill_pool(8);
    valid_gaps = 1'b0;
    holds_requested++;
    repeat (20) random_command(2);
    drain_results();
    valid_gaps = 1'b1;
  endtask

  task automatic test_steady_stream();
    valid_gaps = 1'b0;
    ready_gaps = 1'b0;
    fill_pool(10);
    repeat (60) random_command(2);
  endtask

  // downstream side: random stalls plus requested long holds
  initial begin : sink
    int stall_left;
    int hold_left;
    int holds_served;
    stall_left = 0;
    hold_left = 0;
    holds_served = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (ready_gaps && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic report_field(input string field, input logic [31:0] e, input logic [31:0] a);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, e, a);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      act_r = out_tdata[nbdba_pkg::OUT_USED_W-1:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction: expected none, actual %h",
                 $time, out_tdata);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (act_r.status !== exp_r.status)
          report_field("status", 32'(exp_r.status), 32'(act_r.status));
        if (act_r.offset !== exp_r.offset)
          report_field("offset", 32'(exp_r.offset), 32'(act_r.offset));
        if (act_r.size !== exp_r.size)
          report_field("size", 32'(exp_r.size), 32'(act_r.size));
        if (act_r.slot !== exp_r.slot)
          report_field("slot", 32'(exp_r.slot), 32'(act_r.slot));
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("** named_block_directory_bump_alloc_unit: FAILED **");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= nbdba_pkg::CMD_STORE;
    in_tvalid   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CAP_ADDR;
    cfg_pwdata  <= '0;
    mismatches = 0;
    holds_requested = 0;
    valid_gaps = 1'b1;
    ready_gaps = 1'b1;
    foreach (dir_valid[i]) begin
      dir_valid[i] = 1'b0;
      dir_key[i]   = '0;
      dir_off[i]   = '0;
      dir_size[i]  = '0;
    end
    alloc_ptr = nbdba_pkg::DATA_START;
    capacity_reg = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random_phases();
    test_backpressure();
    test_steady_stream();
    drain_results();
    repeat (DIR_SLOTS + 16) @(posedge clk);
    if (mismatches == 0)
      $display("** named_block_directory_bump_alloc_unit: PASSED **");
    else
      $display("** named_block_directory_bump_alloc_unit: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
hdl/nbdba_pkg.sv
hdl/nbdba_cfg.sv
hdl/nbdba_ctrl.sv
hdl/nbdba_dp.sv
hdl/named_block_directory_bump_alloc_unit.sv
hdl/nbdba_checker.sv
bench/named_block_directory_bump_alloc_unit_tb.sv
